>>> sv/entropy_mixed_lcg_byte_source_assert.svh
// Assertion macros for the entropy byte source, clocked on clock and reset.
`ifndef ENTROPY_MIXED_LCG_BYTE_SOURCE_ASSERT_SVH
`define ENTROPY_MIXED_LCG_BYTE_SOURCE_ASSERT_SVH

`ifndef SYNTHESIS

// check a property outside of reset
`define EMLBS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check a property at every edge, reset included
`define EMLBS_ASSERT_NR(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`else

`define EMLBS_ASSERT(lbl, prop, msg)
`define EMLBS_ASSERT_NR(lbl, prop, msg)

`endif

`endif

>>> sv/emlbs_pkg.sv
// Shared constants, state and command types of the entropy byte source.
package emlbs_pkg;

   // field widths
   localparam int BYTE_COUNT_W = 9;
   localparam int NSEC_W       = 30;

   // default read clamp
   localparam int MAX_READ_BYTES_DEF = 256;

   // generator constants
   localparam logic [31:0] LCG_MULT = 32'd1103515245;
   localparam logic [63:0] LCG_MIX  = 64'd16807;

   // result size of a full word
   localparam logic [2:0] FULL_BYTES = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_MAG,
      ST_FOLD,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic load_event;
      logic load_read;
      logic mul_en;
      logic add_en;
      logic mag_en;
      logic fold_en;
      logic fin_en;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_nonempty;
      logic out_free;
      logic more_after;
   } dp_status_type;

endpackage

>>> sv/emlbs_ctrl.sv
// Sequencer for event capture and the per-word generator steps.
`include "entropy_mixed_lcg_byte_source_assert.svh"

module emlbs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_command,
   input  logic                    req_sample_flag,
   output logic                    req_stall,
   input  emlbs_pkg::dp_status_type sts,
   output emlbs_pkg::ctrl_cmd_type  cmd
);

   emlbs_pkg::state_type state_ff;
   emlbs_pkg::state_type state_in;

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= emlbs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // decode next state and datapath commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = reset | (state_ff != emlbs_pkg::ST_IDLE);
      case (state_ff)
         emlbs_pkg::ST_IDLE: begin
            if (req_valid && !reset) begin
               if (req_command) begin
                  cmd.load_read = 1'b1;
                  if (sts.req_nonempty) begin
                     state_in = emlbs_pkg::ST_MUL;
                  end
               end else begin
                  cmd.load_event = req_sample_flag;
               end
            end
         end
         emlbs_pkg::ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = emlbs_pkg::ST_ADD;
         end
         emlbs_pkg::ST_ADD: begin
            cmd.add_en = 1'b1;
            state_in   = emlbs_pkg::ST_MAG;
         end
         emlbs_pkg::ST_MAG: begin
            cmd.mag_en = 1'b1;
            state_in   = emlbs_pkg::ST_FOLD;
         end
         emlbs_pkg::ST_FOLD: begin
            cmd.fold_en = 1'b1;
            state_in    = emlbs_pkg::ST_FIN;
         end
         emlbs_pkg::ST_FIN: begin
            // wait for room in the output register
            if (sts.out_free) begin
               cmd.fin_en = 1'b1;
               state_in   = sts.more_after ? emlbs_pkg::ST_MUL : emlbs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = emlbs_pkg::ST_IDLE;
         end
      endcase
   end

   `EMLBS_ASSERT(a_fin_waits, (state_ff == emlbs_pkg::ST_FIN) && !sts.out_free |=> (state_ff == emlbs_pkg::ST_FIN), "word finish left while output busy")
   `EMLBS_ASSERT(a_next_word, (state_ff == emlbs_pkg::ST_FIN) && sts.out_free && sts.more_after |=> (state_ff == emlbs_pkg::ST_MUL), "next word of a read not started")
   `EMLBS_ASSERT(a_empty_read, cmd.load_read && !sts.req_nonempty |=> (state_ff == emlbs_pkg::ST_IDLE), "empty read started word generation")
   `EMLBS_ASSERT_NR(a_reset_idle, reset |=> (state_ff == emlbs_pkg::ST_IDLE), "sequencer not idle after reset")

endmodule

>>> sv/emlbs_datapath.sv
// Seed, event state, generator pipeline registers and the result register.
`include "entropy_mixed_lcg_byte_source_assert.svh"

module emlbs_datapath #(
   parameter int MAX_READ_BYTES = emlbs_pkg::MAX_READ_BYTES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [emlbs_pkg::NSEC_W-1:0]        req_event_nsec,
   input  logic [63:0]                         req_tick_count,
   input  logic [emlbs_pkg::BYTE_COUNT_W-1:0]  req_byte_count,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [31:0]                         rsp_rand_bytes,
   output logic [2:0]                          rsp_byte_valid,
   output logic                                rsp_last,
   input  emlbs_pkg::ctrl_cmd_type              cmd,
   output emlbs_pkg::dp_status_type             sts
);

   localparam int CntW = $clog2(MAX_READ_BYTES + 1);
   localparam int CmpW = (CntW > emlbs_pkg::BYTE_COUNT_W) ? CntW : emlbs_pkg::BYTE_COUNT_W;
   localparam int WrdW = CntW - 2;

   // architectural state
   logic [31:0]                  seed_ff, seed_in;
   logic [emlbs_pkg::NSEC_W-1:0] nsec_ff;
   logic [63:0]                  count_ff;

   // per-read and per-word registers
   logic [63:0]        mix_ff;
   logic signed [63:0] prod_ff, prod_in;
   logic [63:0]        acc_ff;
   logic [47:0]        mag_ff, mag_in;
   logic               neg_ff;
   logic [32:0]        fold_ff;
   logic [WrdW-1:0]    words_left_ff;
   logic [1:0]         lefts_ff;

   // result register
   logic        rsp_valid_ff;
   logic [31:0] rsp_bytes_ff, rsp_bytes_in;
   logic [2:0]  rsp_count_ff, rsp_count_in;
   logic        rsp_last_ff;

   logic [CmpW-1:0] bytes_ext;
   logic [CmpW-1:0] bytes_max;
   logic [CmpW-1:0] bytes_clamp;
   logic [CntW-1:0] nbytes;
   logic [31:0]     seed_sum;
   logic [31:0]     seed_abs;
   logic [47:0]     acc_sh;
   logic            wrap;
   logic [31:0]     red;
   logic [31:0]     red_neg;
   logic [31:0]     word;
   logic            full_word;
   logic            more_after;

   // clamp the request size and split into words and tail bytes
   assign bytes_ext   = CmpW'(req_byte_count);
   assign bytes_max   = CmpW'(MAX_READ_BYTES);
   assign bytes_clamp = (bytes_ext > bytes_max) ? bytes_max : bytes_ext;
   assign nbytes      = bytes_clamp[CntW-1:0];

   // fold the last event time into the seed
   assign seed_sum = seed_ff + 32'(nsec_ff);
   assign seed_abs = seed_sum[31] ? (32'd0 - seed_sum) : seed_sum;

   // signed seed times the multiplier constant
   assign prod_in = $signed(seed_ff) * $signed(emlbs_pkg::LCG_MULT);

   // arithmetic shift by 16 and take the magnitude
   assign acc_sh = acc_ff[63:16];
   assign mag_in = acc_ff[63] ? (48'd0 - acc_sh) : acc_sh;

   // finish the mod 2^32-1 reduction, restore sign, take absolute value
   assign wrap    = fold_ff[32] | (&fold_ff[31:0]);
   assign red     = wrap ? (fold_ff[31:0] + 32'd1) : fold_ff[31:0];
   assign red_neg = 32'd0 - red;
   always_comb begin
      if (neg_ff) begin
         word = red_neg[31] ? red : red_neg;
      end else begin
         word = red[31] ? red_neg : red;
      end
   end

   // shape the result and the following seed
   assign full_word  = (words_left_ff != '0);
   assign more_after = (words_left_ff > WrdW'(1))
                     || ((words_left_ff == WrdW'(1)) && (lefts_ff != 2'd0));
   always_comb begin
      if (full_word) begin
         rsp_bytes_in = {word[31:24], word[15:8], word[23:16], word[7:0]};
         rsp_count_in = emlbs_pkg::FULL_BYTES;
         seed_in      = word;
      end else begin
         rsp_count_in = {1'b0, lefts_ff};
         case (lefts_ff)
            2'd1: begin
               rsp_bytes_in = {word[31:24], 24'd0};
               seed_in      = {word[23:0], 8'd0};
            end
            2'd2: begin
               rsp_bytes_in = {word[31:16], 16'd0};
               seed_in      = {word[15:0], 16'd0};
            end
            2'd3: begin
               rsp_bytes_in = {word[31:8], 8'd0};
               seed_in      = {word[7:0], 24'd0};
            end
            default: begin
               rsp_bytes_in = word;
               seed_in      = word;
            end
         endcase
      end
   end

   // update seed, event state and word counters
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff       <= 32'd1;
         nsec_ff       <= '0;
         count_ff      <= '0;
         words_left_ff <= '0;
         lefts_ff      <= '0;
      end else begin
         if (cmd.load_event) begin
            nsec_ff  <= req_event_nsec;
            count_ff <= count_ff + 64'd1;
         end
         if (cmd.load_read) begin
            seed_ff       <= seed_abs;
            words_left_ff <= nbytes[CntW-1:2];
            lefts_ff      <= nbytes[1:0];
         end
         if (cmd.fin_en) begin
            seed_ff <= seed_in;
            if (full_word) begin
               words_left_ff <= words_left_ff - WrdW'(1);
            end else begin
               lefts_ff <= 2'd0;
            end
         end
      end
   end

   // advance the generator pipeline
   always_ff @(posedge clock) begin
      if (cmd.load_read) begin
         mix_ff <= emlbs_pkg::LCG_MIX ^ (count_ff + req_tick_count);
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.add_en) begin
         acc_ff <= 64'(prod_ff) + mix_ff;
      end
      if (cmd.mag_en) begin
         mag_ff <= mag_in;
         neg_ff <= acc_ff[63];
      end
      if (cmd.fold_en) begin
         fold_ff <= {1'b0, mag_ff[31:0]} + 33'(mag_ff[47:32]);
      end
   end

   // hold the result until its transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.fin_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fin_en) begin
         rsp_bytes_ff <= rsp_bytes_in;
         rsp_count_ff <= rsp_count_in;
         rsp_last_ff  <= !more_after;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_rand_bytes = rsp_bytes_ff;
   assign rsp_byte_valid = rsp_count_ff;
   assign rsp_last       = rsp_last_ff;

   assign sts.req_nonempty = (req_byte_count != '0);
   assign sts.out_free     = !rsp_valid_ff || !rsp_stall;
   assign sts.more_after   = more_after;

   `EMLBS_ASSERT(a_fin_room, cmd.fin_en |-> sts.out_free, "result overwritten before transfer")
   `EMLBS_ASSERT(a_short_last, rsp_valid_ff && (rsp_count_ff != emlbs_pkg::FULL_BYTES) |-> rsp_last_ff, "tail result not marked last")
   `EMLBS_ASSERT(a_tail_done, cmd.fin_en && !full_word |=> (lefts_ff == 2'd0) && (words_left_ff == '0), "tail word left work pending")
   `EMLBS_ASSERT_NR(a_reset_empty, reset |=> !rsp_valid_ff, "result valid after reset")

endmodule

>>> sv/entropy_mixed_lcg_byte_source.sv
// Top level of the interrupt-fed random byte source.
//
//  channel | ports                                     | direction
//  --------+-------------------------------------------+----------
//  req     | valid, stall, command, sample_flag,       | in
//          | event_nsec, tick_count, byte_count        |
//  rsp     | valid, stall, rand_bytes, byte_valid, last| out
//
// An event transfer is taken at once while idle. A read is loaded when taken,
// then each result word passes the multiply, add, magnitude, fold and finish steps,
// set by the dependent multiply and mod 2^32-1 chain through the seed register.
// A read keeps the input stalled until its last word has finished, stalls included.
// Reset is synchronous and restores seed 1 and clears the event state.
// A stalled result holds the finish step; the last result of a read may wait
// in the output register while the next request is taken.
module entropy_mixed_lcg_byte_source #(
   parameter int MAX_READ_BYTES = emlbs_pkg::MAX_READ_BYTES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_command,
   input  logic                                req_sample_flag,
   input  logic [emlbs_pkg::NSEC_W-1:0]        req_event_nsec,
   input  logic [63:0]                         req_tick_count,
   input  logic [emlbs_pkg::BYTE_COUNT_W-1:0]  req_byte_count,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [31:0]                         rsp_rand_bytes,
   output logic [2:0]                          rsp_byte_valid,
   output logic                                rsp_last
);

   emlbs_pkg::ctrl_cmd_type  cmd;
   emlbs_pkg::dp_status_type sts;

   // sequence the steps
   emlbs_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_command     (req_command),
      .req_sample_flag (req_sample_flag),
      .req_stall       (req_stall),
      .sts             (sts),
      .cmd             (cmd)
   );

   // compute words and hold results
   emlbs_datapath #(
      .MAX_READ_BYTES (MAX_READ_BYTES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_event_nsec (req_event_nsec),
      .req_tick_count (req_tick_count),
      .req_byte_count (req_byte_count),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_rand_bytes (rsp_rand_bytes),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_last       (rsp_last),
      .cmd            (cmd),
      .sts            (sts)
   );

endmodule
